// ===== rtl/max_window_sum_finder_defines.svh =====
// Assertion macros for the maximum window sum finder.
// Used by the checker; expects signals clk and arst_n in scope.
`ifndef MAX_WINDOW_SUM_FINDER_DEFINES_SVH
`define MAX_WINDOW_SUM_FINDER_DEFINES_SVH

// same-cycle implication
`define MWSF_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define MWSF_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/mwsf_pkg.sv =====
// Shared types and fixed field widths for the maximum window sum finder.
// No dependencies.
package mwsf_pkg;

	localparam int SAMPLE_W = 16;
	localparam int LEN_W    = 12;
	localparam int PEAK_W   = 27;
	localparam int START_W  = 20;
	localparam logic [LEN_W-1:0]  LEN_RESET = 12'd1500;
	localparam logic [PEAK_W-1:0] PEAK_MAX  = '1;

	// per-stage control flags
	typedef struct packed {
		logic valid;
		logic last;
		logic full_before;  // window already full before this word
		logic full_after;   // window full including this word
	} ctrl_t;

	typedef struct packed {
		logic               window_seen;
		logic [START_W-1:0] peak_start;
		logic [PEAK_W-1:0]  peak_sum;
	} result_t;

endpackage

// ===== rtl/mwsf_ring.sv =====
// Sample ring memory with pointer and count; first pipeline stage.
// Depends on mwsf_pkg.
module mwsf_ring #(
	parameter int WINDOW_MAX = 2048,
	parameter int COUNT_BITS = 20
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           clr,
	input  logic [mwsf_pkg::LEN_W-1:0]     len,
	input  logic                           accept,
	input  logic                           advance,
	input  logic [mwsf_pkg::SAMPLE_W-1:0]  sample,
	input  logic                           last,
	output mwsf_pkg::ctrl_t                ctrl_s1,
	output logic [mwsf_pkg::SAMPLE_W-1:0]  sample_s1,
	output logic [mwsf_pkg::SAMPLE_W-1:0]  old_s1,
	output logic [mwsf_pkg::START_W-1:0]   start_s1
);
	import mwsf_pkg::*;

	localparam int PTR_W = $clog2(WINDOW_MAX);
	localparam int EXT_W = (COUNT_BITS > START_W) ? COUNT_BITS : START_W;
	localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

	logic [SAMPLE_W-1:0]   ring_mem [WINDOW_MAX];
	logic [PTR_W-1:0]      ptr_q;
	logic [COUNT_BITS-1:0] count_q;
	logic [PTR_W-1:0]      addr;
	logic [PTR_W-1:0]      ptr_next;
	logic [COUNT_BITS-1:0] count_next;
	logic [COUNT_BITS-1:0] len_c;
	logic [COUNT_BITS-1:0] start_c;
	logic [EXT_W-1:0]      start_ext;

	always_comb begin
		len_c      = COUNT_BITS'(len);
		addr       = (32'(ptr_q) >= 32'(len)) ? '0 : ptr_q;
		ptr_next   = (32'(addr) + 32'd1 == 32'(len)) ? '0 : addr + PTR_W'(1);
		count_next = (count_q == COUNT_MAX) ? count_q : count_q + COUNT_BITS'(1);
		start_c    = count_next - len_c;
		start_ext  = EXT_W'(start_c);
	end

	// read-first: the old entry comes out while the new sample goes in
	always_ff @(posedge clk) begin
		if (accept) begin
			ring_mem[addr] <= sample;
			old_s1         <= ring_mem[addr];
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			sample_s1 <= sample;
			start_s1  <= start_ext[START_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q   <= '0;
			count_q <= '0;
			ctrl_s1 <= '0;
		end else begin
			if (clr) begin
				ptr_q   <= '0;
				count_q <= '0;
			end else if (accept) begin
				// drop stream position after the closing word
				ptr_q   <= last ? '0 : ptr_next;
				count_q <= last ? '0 : count_next;
			end
			if (advance) begin
				ctrl_s1.valid       <= accept;
				ctrl_s1.last        <= last;
				ctrl_s1.full_before <= count_q >= len_c;
				ctrl_s1.full_after  <= count_next >= len_c;
			end
		end
	end

endmodule

// ===== rtl/mwsf_accum.sv =====
// Running window sum and peak tracking; second and third pipeline stages.
// Depends on mwsf_pkg.
module mwsf_accum #(
	parameter int WINDOW_MAX = 2048
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           clr,
	input  logic                           advance,
	input  mwsf_pkg::ctrl_t                ctrl_s1,
	input  logic [mwsf_pkg::SAMPLE_W-1:0]  sample_s1,
	input  logic [mwsf_pkg::SAMPLE_W-1:0]  old_s1,
	input  logic [mwsf_pkg::START_W-1:0]   start_s1,
	output mwsf_pkg::ctrl_t                ctrl_s2,
	output logic                           res_valid,
	output mwsf_pkg::result_t              res
);
	import mwsf_pkg::*;

	localparam int SUM_W = SAMPLE_W + $clog2(WINDOW_MAX);
	localparam int EXT_W = (SUM_W > PEAK_W) ? SUM_W : PEAK_W;

	logic [SUM_W-1:0]   sum_q;
	logic [SUM_W-1:0]   sum_next;
	logic [SUM_W-1:0]   sum_s2;
	logic [START_W-1:0] start_s2;
	logic [SUM_W-1:0]   best_q;
	logic [START_W-1:0] best_start_q;
	logic [SUM_W-1:0]   best_next;
	logic [START_W-1:0] best_start_next;
	logic [EXT_W-1:0]   best_ext;

	always_comb begin
		sum_next = sum_q - (ctrl_s1.full_before ? SUM_W'(old_s1) : '0) + SUM_W'(sample_s1);
		// strictly greater keeps the earliest window on a tie
		if (ctrl_s2.full_after && (sum_s2 > best_q)) begin
			best_next       = sum_s2;
			best_start_next = start_s2;
		end else begin
			best_next       = best_q;
			best_start_next = best_start_q;
		end
		best_ext        = EXT_W'(best_next);
		res.peak_sum    = (best_ext > EXT_W'(PEAK_MAX)) ? PEAK_MAX : best_ext[PEAK_W-1:0];
		res.peak_start  = best_start_next;
		res.window_seen = ctrl_s2.full_after;
		res_valid       = advance && ctrl_s2.valid && ctrl_s2.last;
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			sum_s2   <= sum_next;
			start_s2 <= start_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q        <= '0;
			best_q       <= '0;
			best_start_q <= '0;
			ctrl_s2      <= '0;
		end else begin
			if (advance) begin
				ctrl_s2 <= ctrl_s1;
			end
			if (clr) begin
				sum_q <= '0;
			end else if (advance && ctrl_s1.valid) begin
				sum_q <= ctrl_s1.last ? '0 : sum_next;
			end
			if (clr) begin
				best_q       <= '0;
				best_start_q <= '0;
			end else if (advance && ctrl_s2.valid) begin
				best_q       <= ctrl_s2.last ? '0 : best_next;
				best_start_q <= ctrl_s2.last ? '0 : best_start_next;
			end
		end
	end

endmodule

// ===== rtl/max_window_sum_finder.sv =====
// Maximum sliding window sum finder, top level.
// Last sample: ctrl_s1, ctrl_s2, out_valid_q; one word per cycle unless held.
// Throughput is set by the single read-first ring port: one read and one write a cycle.
// Reset clears sums, count, pointer and peak and sets window_len to 1500.
// Ring contents stay undefined after reset; entries are read only once written.
module max_window_sum_finder #(
	parameter int WINDOW_MAX = 2048,
	parameter int COUNT_BITS = 20
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [11:0] cfg_data,   // window_len
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,    // sample
	input  logic        s_tlast,    // last
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,    // peak_sum [26:0], peak_start [46:27], zero pad
	output logic        m_tuser     // window_seen
);
	import mwsf_pkg::*;

	logic [LEN_W-1:0]    cfg_q;
	logic [LEN_W-1:0]    len_eff;
	logic                hold;
	logic                accept;
	ctrl_t               ctrl_s1;
	ctrl_t               ctrl_s2;
	logic [SAMPLE_W-1:0] sample_s1;
	logic [SAMPLE_W-1:0] old_s1;
	logic [START_W-1:0]  start_s1;
	logic                res_valid;
	result_t             res;
	logic                out_valid_q;
	result_t             out_q;

	always_comb begin
		if (cfg_q == '0) begin
			len_eff = LEN_W'(1);
		end else if (32'(cfg_q) > WINDOW_MAX) begin
			len_eff = LEN_W'(WINDOW_MAX);
		end else begin
			len_eff = cfg_q;
		end
		// stall only while a closing word cannot reach the output register
		hold     = ctrl_s2.valid && ctrl_s2.last && out_valid_q && !m_tready;
		s_tready = !hold;
		accept   = s_tvalid && !hold;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= LEN_RESET;
		end else if (cfg_we) begin
			cfg_q <= cfg_data;
		end
	end

	mwsf_ring #(
		.WINDOW_MAX (WINDOW_MAX),
		.COUNT_BITS (COUNT_BITS)
	) u_ring (
		.clk       (clk),
		.arst_n    (arst_n),
		.clr       (cfg_we),
		.len       (len_eff),
		.accept    (accept),
		.advance   (!hold),
		.sample    (s_tdata),
		.last      (s_tlast),
		.ctrl_s1   (ctrl_s1),
		.sample_s1 (sample_s1),
		.old_s1    (old_s1),
		.start_s1  (start_s1)
	);

	mwsf_accum #(
		.WINDOW_MAX (WINDOW_MAX)
	) u_accum (
		.clk       (clk),
		.arst_n    (arst_n),
		.clr       (cfg_we),
		.advance   (!hold),
		.ctrl_s1   (ctrl_s1),
		.sample_s1 (sample_s1),
		.old_s1    (old_s1),
		.start_s1  (start_s1),
		.ctrl_s2   (ctrl_s2),
		.res_valid (res_valid),
		.res       (res)
	);

	always_ff @(posedge clk) begin
		if (res_valid) begin
			out_q <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {1'b0, out_q.peak_start, out_q.peak_sum};
	assign m_tuser  = out_q.window_seen;

endmodule

// ===== rtl/mwsf_checker.sv =====
// Port-level checks for max_window_sum_finder, bound to the top level.
// Depends on max_window_sum_finder_defines.svh.
`include "max_window_sum_finder_defines.svh"

module mwsf_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [47:0] m_tdata,
	input logic        m_tuser
);

	// a waiting result word holds
	`MWSF_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result word changed while stalled")
	// input side only stalls behind a full output register
	`MWSF_ASSERT_NOW(a_ready_free, !m_tvalid, s_tready, "input stalled with output register empty")
	// a nonzero peak needs a full window
	`MWSF_ASSERT_NOW(a_sum_seen, m_tvalid && (m_tdata[26:0] != 27'd0), m_tuser, "peak sum without full window")
	// no full window leaves the start index at zero
	`MWSF_ASSERT_NOW(a_start_zero, m_tvalid && !m_tuser, m_tdata[46:27] == 20'd0, "peak start set without full window")

endmodule

bind max_window_sum_finder mwsf_checker u_mwsf_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

// ===== sim/tb_max_window_sum_finder.sv =====
// Self-checking testbench for max_window_sum_finder: streams of rate samples in,
// peak window sums out, checked against an in-bench predictor of the window search.
// Depends on mwsf_pkg and the max_window_sum_finder RTL.
module tb_max_window_sum_finder;
	import mwsf_pkg::*;

	localparam int WINDOW_MAX     = 2048;
	localparam int COUNT_BITS     = 20;
	localparam int COUNT_MAX      = (1 << COUNT_BITS) - 1;
	localparam int IDLE_PCT       = 12;
	localparam int SETTLE_CYCLES  = 8;
	localparam int DRAIN_CYCLES   = 16;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int RANDOM_ITEMS   = 600;
	localparam int BACKLOG_DEPTH  = 256;

	typedef struct packed {
		logic                last;
		logic [SAMPLE_W-1:0] sample;
	} sample_word_t;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        cfg_we   = 1'b0;
	logic [11:0] cfg_data = '0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata  = '0;
	logic        s_tlast  = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [47:0] m_tdata;
	logic        m_tuser;

	logic         quiet = 1'b0;
	sample_word_t sample_backlog [$];
	result_t      results_due [$];
	int unsigned  fail_count = 0;
	int unsigned  stall_cnt  = 0;

	// predictor state
	logic [SAMPLE_W-1:0] win_ring [WINDOW_MAX];
	logic [31:0]         win_sum   = '0;
	logic [19:0]         seen_cnt  = '0;
	logic [31:0]         top_sum   = '0;
	logic [19:0]         top_start = '0;
	int unsigned         wr_slot   = 0;
	logic [LEN_W-1:0]    win_len   = LEN_RESET;

	max_window_sum_finder #(
		.WINDOW_MAX(WINDOW_MAX),
		.COUNT_BITS(COUNT_BITS)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_data(cfg_data),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tlast(s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser)
	);

	always #1 clk = ~clk;

	function automatic int unsigned span_of(input logic [LEN_W-1:0] len);
		if (len == 0) begin
			return 1;
		end
		if (len > WINDOW_MAX) begin
			return WINDOW_MAX;
		end
		return 32'(len);
	endfunction

	function automatic logic [SAMPLE_W-1:0] pick_sample(input int unsigned flavour);
		case (flavour)
			0: begin
				return SAMPLE_W'($urandom);
			end
			1: begin
				return SAMPLE_W'($urandom_range(0, 15));
			end
			2: begin
				return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
			end
			default: begin
				return SAMPLE_W'(16'hFFFF - $urandom_range(0, 15));
			end
		endcase
	endfunction

	task automatic clear_search();
		win_sum   = '0;
		seen_cnt  = '0;
		top_sum   = '0;
		top_start = '0;
		wr_slot   = 0;
	endtask

	task automatic track_sample(input sample_word_t w);
		int unsigned span;
		result_t     res;
		span = span_of(win_len);
		if (wr_slot >= span) begin
			wr_slot = 0;
		end
		// drop the oldest sample once the window is full
		if (seen_cnt >= span) begin
			win_sum = win_sum - win_ring[wr_slot];
		end
		win_ring[wr_slot] = w.sample;
		win_sum = win_sum + w.sample;
		wr_slot = (wr_slot + 1 == span) ? 0 : wr_slot + 1;
		if (seen_cnt != COUNT_MAX) begin
			seen_cnt = seen_cnt + 1'b1;
		end
		// strictly larger only, so the earliest of equal windows stays
		if (seen_cnt >= span && win_sum > top_sum) begin
			top_sum   = win_sum;
			top_start = 20'(seen_cnt - span);
		end
		if (w.last) begin
			res.peak_sum    = (top_sum > PEAK_MAX) ? PEAK_MAX : top_sum[PEAK_W-1:0];
			res.peak_start  = top_start;
			res.window_seen = (seen_cnt >= span);
			results_due.insert(results_due.size(), res);
			clear_search();
		end
	endtask

	// input side of the predictor
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_we) begin
				win_len = cfg_data;
				clear_search();
			end
			if (s_tvalid && s_tready) begin
				track_sample('{last: s_tlast, sample: s_tdata});
			end
		end
	end

	// sample driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (!s_tvalid || s_tready) begin
				if (sample_backlog.size() != 0 && (quiet || $urandom_range(0, 99) >= IDLE_PCT)) begin
					{s_tlast, s_tdata} <= sample_backlog.pop_front();
					s_tvalid <= 1'b1;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// result monitor
	always @(posedge clk) begin
		result_t want;
		if (arst_n) begin
			m_tready <= quiet || ($urandom_range(0, 99) >= IDLE_PCT);
			if (m_tvalid && m_tready) begin
				if (results_due.size() == 0) begin
					$error("result word with no pending expectation: tdata %h tuser %b",
						m_tdata, m_tuser);
					fail_count++;
				end else begin
					want = results_due.pop_front();
					if (m_tdata[26:0] !== want.peak_sum) begin
						$error("peak_sum mismatch: expected %0d, actual %0d",
							want.peak_sum, m_tdata[26:0]);
						fail_count++;
					end
					if (m_tdata[46:27] !== want.peak_start) begin
						$error("peak_start mismatch: expected %0d, actual %0d",
							want.peak_start, m_tdata[46:27]);
						fail_count++;
					end
					if (m_tuser !== want.window_seen) begin
						$error("window_seen mismatch: expected %0d, actual %0d",
							want.window_seen, m_tuser);
						fail_count++;
					end
					if (m_tdata[47] !== 1'b0) begin
						$error("tdata pad mismatch: expected 0, actual %b", m_tdata[47]);
						fail_count++;
					end
				end
			end
		end
	end

	// watchdog on handshake activity
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
				stall_cnt <= 0;
			end else if (stall_cnt == WATCHDOG_LIMIT) begin
				$display("[FAIL] regression broken");
				$finish;
			end else begin
				stall_cnt <= stall_cnt + 1;
			end
		end
	end

	task automatic push_word(input logic [SAMPLE_W-1:0] sample, input logic last);
		sample_word_t w;
		while (sample_backlog.size() >= BACKLOG_DEPTH) begin
			@(posedge clk);
		end
		w.last   = last;
		w.sample = sample;
		sample_backlog.insert(sample_backlog.size(), w);
	endtask

	task automatic push_stream(input int unsigned len, input int unsigned flavour,
			input logic closed);
		for (int unsigned i = 0; i < len; i++) begin
			push_word(pick_sample(flavour), closed && (i == len - 1));
		end
	endtask

	// hold until every word is in and every result is out, then let the pipe empty
	task automatic settle();
		while (sample_backlog.size() != 0 || s_tvalid || results_due.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_window(input logic [LEN_W-1:0] len);
		settle();
		cfg_data <= len;
		cfg_we   <= 1'b1;
		@(posedge clk);
		cfg_we   <= 1'b0;
	endtask

	initial begin
		int unsigned random_items;
		int unsigned phase;
		int unsigned r;
		int unsigned span;
		int unsigned len;
		logic [LEN_W-1:0] win;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset length of 1500: stream far too short for a window
		push_word(16'hFFFF, 1'b0);
		push_word(16'h0000, 1'b0);
		push_word(16'h0001, 1'b1);

		// single-sample window, equal peaks keep the earlier one
		set_window(12'd1);
		push_word(16'h0000, 1'b0);
		push_word(16'hFFFF, 1'b0);
		push_word(16'hFFFF, 1'b0);
		push_word(16'h0007, 1'b1);

		// zero length behaves as one
		set_window(12'd0);
		push_word(16'h0005, 1'b0);
		push_word(16'hFFFF, 1'b1);

		// all-zero windows report zero at index zero
		set_window(12'd3);
		repeat (3) push_word(16'h0000, 1'b0);
		push_word(16'h0000, 1'b1);

		// tie between two windows of sum 8
		push_word(16'd1, 1'b0);
		push_word(16'd2, 1'b0);
		push_word(16'd3, 1'b0);
		push_word(16'd3, 1'b0);
		push_word(16'd2, 1'b0);
		push_word(16'd1, 1'b1);

		// abandon a stream mid-way; the register write restarts at index zero
		repeat (4) push_word(16'd9, 1'b0);
		set_window(12'd2);
		push_word(16'd4, 1'b0);
		push_word(16'h8000, 1'b0);
		push_word(16'd1, 1'b1);

		random_items = 0;
		phase = 0;
		while (random_items < RANDOM_ITEMS) begin
			r = $urandom_range(0, 99);
			if (r < 70) begin
				win = LEN_W'($urandom_range(1, 16));
			end else if (r < 92) begin
				win = LEN_W'($urandom_range(17, 80));
			end else if (r < 96) begin
				win = '0;
			end else begin
				win = LEN_W'($urandom_range(81, 200));
			end
			set_window(win);
			quiet <= (phase >= 3 && phase < 6);
			span = span_of(win);
			repeat ($urandom_range(1, 4)) begin
				r = $urandom_range(0, 99);
				if (r < 25) begin
					len = $urandom_range(1, span);
				end else if (r < 50) begin
					len = span + $urandom_range(0, 2);
				end else begin
					len = span + $urandom_range(0, 3 * span + 8);
				end
				push_stream(len, $urandom_range(0, 3), 1'b1);
				random_items += len;
			end
			// now and then leave an unfinished stream for the next write to clear
			if ($urandom_range(0, 3) == 0) begin
				len = $urandom_range(1, span + 3);
				push_stream(len, $urandom_range(0, 3), 1'b0);
				random_items += len;
			end
			phase++;
		end

		// oversized length clamps to the ring depth
		set_window(12'hFFF);
		quiet <= 1'b0;
		push_stream(24, 0, 1'b1);

		while (sample_backlog.size() != 0 || s_tvalid || results_due.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0 && results_due.size() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
